>>> src/bgsp_pkg.sv
// shared types and constants for the binary geometry stream parser
// used by bgsp_ffp, bgsp_parser and binary_geometry_stream_parser
package bgsp_pkg;

    // parse phases
    localparam logic [2:0] PH_SIG   = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_COORD = 3'd2;
    localparam logic [2:0] PH_NVERT = 3'd3;
    localparam logic [2:0] PH_INDEX = 3'd4;
    localparam logic [2:0] PH_COLOR = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_COORD  = 3'd1;
    localparam logic [2:0] KIND_INDEX  = 3'd2;
    localparam logic [2:0] KIND_POLY   = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    // final status codes
    localparam logic [31:0] ST_OK    = 32'd0;
    localparam logic [31:0] ST_NOREC = 32'd1;
    localparam logic [31:0] ST_BAD   = 32'd2;
    localparam logic [31:0] ST_ASCII = 32'd3;

    // coordinate axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [31:0] SIG_BIN   = 32'h3344_4231;
    localparam logic [31:0] SIG_ASC   = 32'h3344_4731;
    localparam logic [7:0]  FFP_BIAS  = 8'd62;
    localparam logic [15:0] COLOR_MAX = 16'd15;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  axis;
        logic [31:0] value;
        logic [15:0] vert_count;
    } t_result;

endpackage

>>> src/bgsp_ffp.sv
// converts a motorola fast floating point word to ieee single bits
// depends on bgsp_pkg
module bgsp_ffp (
    input  logic [31:0] i_word,
    output logic [31:0] o_bits
);

    logic       w_sign;
    logic [6:0] w_exp;
    logic [23:0] w_mant;
    logic [7:0] w_ieee_exp;

    assign w_sign     = i_word[7];
    assign w_exp      = i_word[6:0];
    assign w_mant     = i_word[31:8];
    assign w_ieee_exp = {1'b0, w_exp} + bgsp_pkg::FFP_BIAS;

    // zero exponent or mantissa (and so a zero word) reads as +0
    always_comb begin
        if (w_exp == 7'd0 || w_mant == 24'd0) begin
            o_bits = 32'd0;
        end else begin
            o_bits = {w_sign, w_ieee_exp, w_mant[22:0]};
        end
    end

endmodule

>>> src/bgsp_parser.sv
// parse state and per-byte next-state logic, one item per step
// depends on bgsp_pkg and bgsp_ffp
module bgsp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_start_of_file,
    input  logic                 i_end_of_file,
    input  logic [7:0]           i_data_byte,
    output logic                 o_res_valid,
    output bgsp_pkg::t_result    o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [1:0]  r_bpos, n_bpos;
    logic [15:0] r_points, n_points;
    logic [1:0]  r_axis, n_axis;
    logic [15:0] r_verts, n_verts;
    logic [15:0] r_poly, n_poly;
    logic        r_fin, n_fin;

    logic [31:0] w_word;
    logic [31:0] w_ffp;
    logic [1:0]  w_bpos_inc;
    logic [1:0]  w_need;
    logic [15:0] w_color;
    logic [15:0] w_mag;
    logic [15:0] w_points_dec;
    logic [15:0] w_verts_dec;

    bgsp_ffp u_ffp (
        .i_word (w_word),
        .o_bits (w_ffp)
    );

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bpos      = r_bpos;
        n_points    = r_points;
        n_axis      = r_axis;
        n_verts     = r_verts;
        n_poly      = r_poly;
        n_fin       = r_fin;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_start_of_file) begin
            n_phase  = bgsp_pkg::PH_SIG;
            n_shift  = 32'd0;
            n_bpos   = 2'd0;
            n_points = 16'd0;
            n_axis   = 2'd0;
            n_verts  = 16'd0;
            n_poly   = 16'd0;
            n_fin    = 1'b0;
        end

        w_word       = {n_shift[23:0], i_data_byte};
        w_bpos_inc   = n_bpos + 2'd1;
        w_need       = (n_phase == bgsp_pkg::PH_SIG || n_phase == bgsp_pkg::PH_COORD)
                       ? 2'd0 : 2'd2;
        w_color      = w_word[15:0];
        w_mag        = w_color[15] ? (16'd0 - w_color) : w_color;
        w_points_dec = n_points - 16'd1;
        w_verts_dec  = n_verts - 16'd1;

        if (!n_fin) begin
            if (i_end_of_file) begin
                n_fin             = 1'b1;
                o_res_valid       = 1'b1;
                o_res.kind        = bgsp_pkg::KIND_STATUS;
                o_res.value       = (n_phase == bgsp_pkg::PH_NVERT) ? bgsp_pkg::ST_OK
                                                                    : bgsp_pkg::ST_BAD;
            end else if (w_bpos_inc != w_need) begin
                n_shift = w_word;
                n_bpos  = w_bpos_inc;
            end else begin
                n_shift = 32'd0;
                n_bpos  = 2'd0;
                case (n_phase)
                    bgsp_pkg::PH_SIG: begin
                        if (w_word == bgsp_pkg::SIG_BIN) begin
                            n_phase = bgsp_pkg::PH_COUNT;
                        end else begin
                            n_fin       = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = bgsp_pkg::KIND_STATUS;
                            o_res.value = (w_word == bgsp_pkg::SIG_ASC)
                                          ? bgsp_pkg::ST_ASCII : bgsp_pkg::ST_NOREC;
                        end
                    end
                    bgsp_pkg::PH_COUNT: begin
                        n_points    = w_word[15:0];
                        n_axis      = bgsp_pkg::AXIS_X;
                        n_phase     = (w_word[15:0] == 16'd0) ? bgsp_pkg::PH_NVERT
                                                              : bgsp_pkg::PH_COORD;
                        o_res_valid = 1'b1;
                        o_res.kind  = bgsp_pkg::KIND_COUNT;
                        o_res.value = {16'd0, w_word[15:0]};
                    end
                    bgsp_pkg::PH_COORD: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = bgsp_pkg::KIND_COORD;
                        o_res.axis  = n_axis;
                        o_res.value = w_ffp;
                        if (n_axis == bgsp_pkg::AXIS_Z) begin
                            // z axis points the other way
                            o_res.value = {~w_ffp[31], w_ffp[30:0]};
                            n_axis      = bgsp_pkg::AXIS_X;
                            n_points    = w_points_dec;
                            if (w_points_dec == 16'd0) begin
                                n_phase = bgsp_pkg::PH_NVERT;
                            end
                        end else begin
                            n_axis = n_axis + 2'd1;
                        end
                    end
                    bgsp_pkg::PH_NVERT: begin
                        if (w_word[15:0] == 16'd0) begin
                            n_fin       = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = bgsp_pkg::KIND_STATUS;
                            o_res.value = bgsp_pkg::ST_OK;
                        end else begin
                            n_verts = w_word[15:0];
                            n_poly  = w_word[15:0];
                            n_phase = bgsp_pkg::PH_INDEX;
                        end
                    end
                    bgsp_pkg::PH_INDEX: begin
                        n_verts = w_verts_dec;
                        if (w_verts_dec == 16'd0) begin
                            n_phase = bgsp_pkg::PH_COLOR;
                        end
                        o_res_valid = 1'b1;
                        o_res.kind  = bgsp_pkg::KIND_INDEX;
                        o_res.value = {16'd0, w_word[15:0]};
                    end
                    default: begin
                        n_phase          = bgsp_pkg::PH_NVERT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = bgsp_pkg::KIND_POLY;
                        o_res.value      = {16'd0, (w_mag > bgsp_pkg::COLOR_MAX)
                                                   ? bgsp_pkg::COLOR_MAX : w_mag};
                        o_res.vert_count = n_poly;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bgsp_pkg::PH_SIG;
            r_shift  <= 32'd0;
            r_bpos   <= 2'd0;
            r_points <= 16'd0;
            r_axis   <= 2'd0;
            r_verts  <= 16'd0;
            r_poly   <= 16'd0;
            r_fin    <= 1'b1;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_bpos   <= n_bpos;
            r_points <= n_points;
            r_axis   <= n_axis;
            r_verts  <= n_verts;
            r_poly   <= n_poly;
            r_fin    <= n_fin;
        end
    end

endmodule

>>> src/binary_geometry_stream_parser.sv
// Binary geometry stream parser (3DB1 layout), top level.
//
// Input channel: one file byte per item on i_data_byte, handshaken by
// i_in_valid / o_in_ready. i_start_of_file marks the first signature
// byte and restarts parsing; i_end_of_file marks the end of the file
// and its data byte is ignored.
// Output channel: zero or one result item per input item, handshaken by
// o_out_valid / i_out_ready, with o_kind, o_axis, o_value, o_vert_count.
// Path: each accepted byte is held in the input register, parsed, and
// its result is loaded into the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// combinational parse step between the input register and the result register.
// Reset: the parser is idle and ignores bytes until a start of file;
// both register stages are emptied.
// Stall: while the result register is full and not taken, the parse
// step holds; one more byte waits in the input register, then
// o_in_ready drops.
// depends on bgsp_pkg and bgsp_parser
module binary_geometry_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_of_file,
    input  logic        i_end_of_file,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_axis,
    output logic [31:0] o_value,
    output logic [15:0] o_vert_count
);

    logic              r_in_valid;
    logic              r_sof;
    logic              r_eof;
    logic [7:0]        r_byte;
    logic              r_out_valid;
    bgsp_pkg::t_result r_out;

    logic              w_step;
    logic              w_res_valid;
    bgsp_pkg::t_result w_res;

    // parse step fires when an input byte is held and the result slot is free or being drained
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    bgsp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_start_of_file (r_sof),
        .i_end_of_file   (r_eof),
        .i_data_byte     (r_byte),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sof  <= i_start_of_file;
            r_eof  <= i_end_of_file;
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_axis       = r_out.axis;
    assign o_value      = r_out.value;
    assign o_vert_count = r_out.vert_count;

`ifndef SYNTHESIS
    // a held input byte is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_byte))
        else $error("input stage dropped a waiting item");

    // axis is only meaningful on coordinates
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != bgsp_pkg::KIND_COORD |-> o_axis == 2'd0)
        else $error("axis set on a non-coordinate result");

    // polygon end carries a nonzero vertex count, others carry none
    a_vcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == bgsp_pkg::KIND_POLY) == (o_vert_count != 16'd0)))
        else $error("vertex count inconsistent with result kind");

    // a fresh result appears only after a parse step
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_step))
        else $error("result appeared without a parse step");
`endif

endmodule
